// ===== hw/rtl/tbqs_pkg.sv =====
package tbqs_pkg;

    // Counter widths
    localparam int LENGTH_BITS   = 32;
    localparam int WORD_LEN_BITS = 16;
    localparam int CNT_BITS      = 8;

    // Q1.16 ratios with room for exactly one
    localparam int Q_BITS    = 17;
    localparam int FRAC_BITS = 16;
    localparam int STEP_BITS = $clog2(Q_BITS + 1);

    localparam logic [LENGTH_BITS-1:0]   LEN_MAX  = '1;
    localparam logic [WORD_LEN_BITS-1:0] WLEN_MAX = '1;
    localparam logic [CNT_BITS-1:0]      CNT_MAX  = '1;
    localparam logic [Q_BITS-1:0]        Q_ONE    = Q_BITS'(1) << FRAC_BITS;
    localparam logic [1:0]               LINE_SAT = 2'd2;

    // Score: floor(sum / 10) as a multiply by a rounded-up reciprocal,
    // exact for every sum below 2^20
    localparam int SUM_BITS     = 20;
    localparam int PROD_BITS    = 2 * SUM_BITS;
    localparam int DIV10_SHIFT  = 23;
    localparam logic [SUM_BITS-1:0] DIV10_MUL = SUM_BITS'(838861);

    // floor(lines / 3) for 8-bit values: (x * 171) >> 9
    localparam int DIV3_SHIFT = 9;
    localparam logic [CNT_BITS-1:0] DIV3_MUL = CNT_BITS'(171);

    // Configuration port
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // Beat queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        REG_MIN_READABILITY   = 3'd0,
        REG_MIN_WORD_QUALITY  = 3'd1,
        REG_WARNING_THRESHOLD = 3'd2,
        REG_WORD_LIMIT        = 3'd3,
        REG_LINE_LIMIT        = 3'd4,
        REG_SPACE_RUN_LIMIT   = 3'd5,
        REG_CONTROL_LIMIT     = 3'd6,
        REG_MIN_LINES         = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        WARN_NONE         = 3'd0,
        WARN_EMPTY        = 3'd1,
        WARN_READABILITY  = 3'd2,
        WARN_WORD_QUALITY = 3'd3,
        WARN_SCORE        = 3'd4
    } warn_t;

    typedef enum logic [2:0] {
        ST_BYTE,
        ST_CLOSE,
        ST_WAIT_R,
        ST_WAIT_W,
        ST_SCORE,
        ST_FIN
    } back_state_t;

    typedef struct packed {
        logic [Q_BITS-1:0]   min_readability;
        logic [Q_BITS-1:0]   min_word_quality;
        logic [Q_BITS-1:0]   warning_threshold;
        logic [CNT_BITS-1:0] word_limit;
        logic [CNT_BITS-1:0] line_limit;
        logic [CNT_BITS-1:0] space_run_limit;
        logic [CNT_BITS-1:0] control_limit;
        logic [CNT_BITS-1:0] min_lines;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        min_readability:   Q_BITS'(52429),
        min_word_quality:  Q_BITS'(32768),
        warning_threshold: Q_BITS'(39322),
        word_limit:        CNT_BITS'(200),
        line_limit:        CNT_BITS'(100),
        space_run_limit:   CNT_BITS'(20),
        control_limit:     CNT_BITS'(10),
        min_lines:         CNT_BITS'(10)
    };

    // One classified byte
    typedef struct packed {
        logic last;
        logic present;
        logic readable;
        logic separator;
        logic letter;
        logic space;
        logic control;
        logic newline;
    } beat_t;

    typedef struct packed {
        logic                   start;
        logic [LENGTH_BITS-1:0] dividend;
        logic [LENGTH_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [Q_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/tbqs_front.sv =====
module tbqs_front (
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      text_byte,
    input  logic            byte_present,
    input  logic            last_byte,
    input  logic            q_full,
    output logic            q_push,
    output tbqs_pkg::beat_t q_beat
);
    import tbqs_pkg::*;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic [7:0] folded;

    assign folded   = text_byte | 8'h20;
    assign in_ready = !q_full;
    // drop idle beats here: they change nothing downstream
    assign q_push   = in_valid && !q_full && (byte_present || last_byte);

    always_comb
    begin
        q_beat           = '0;
        q_beat.last      = last_byte;
        q_beat.present   = byte_present;
        q_beat.readable  = text_byte inside {[8'h20:8'h7E], CH_TAB, CH_LF, CH_CR,
                                             [8'h80:8'hF4]};
        q_beat.separator = text_byte inside {[CH_TAB:CH_CR], CH_SPACE};
        q_beat.letter    = folded inside {[8'h61:8'h7A]};
        q_beat.space     = (text_byte == CH_SPACE);
        q_beat.control   = (text_byte < CH_SPACE) && !(text_byte inside {CH_TAB, CH_LF, CH_CR});
        q_beat.newline   = (text_byte == CH_LF);
    end

endmodule

// ===== hw/rtl/tbqs_queue.sv =====
module tbqs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tbqs_pkg::beat_t push_beat,
    output logic            full,
    input  logic            pop,
    output tbqs_pkg::beat_t pop_beat,
    output logic            empty
);
    import tbqs_pkg::*;

    beat_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg,  count_next;

    assign full     = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_beat = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

// ===== hw/rtl/tbqs_div.sv =====
module tbqs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tbqs_pkg::div_req_t req,
    output tbqs_pkg::div_rsp_t rsp
);
    import tbqs_pkg::*;

    // Restoring division of a <= b: one quotient bit per cycle, integer bit first
    logic [LENGTH_BITS:0]   rem_reg;
    logic [LENGTH_BITS-1:0] den_reg;
    logic [Q_BITS-1:0]      quo_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   load;
    logic                   take;
    logic [LENGTH_BITS:0]   rem_sel;
    logic [LENGTH_BITS:0]   rem_next;

    assign load     = req.start && !busy_reg;
    assign take     = (rem_reg >= {1'b0, den_reg});
    assign rem_sel  = take ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    assign rem_next = {rem_sel[LENGTH_BITS-1:0], 1'b0};

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(Q_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= {1'b0, req.dividend};
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[Q_BITS-2:0], take};
        end
    end

endmodule

// ===== hw/rtl/tbqs_back.sv =====
module tbqs_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tbqs_pkg::cfg_t                 cfg,
    input  logic                           q_empty,
    input  tbqs_pkg::beat_t                q_beat,
    output logic                           q_pop,
    output tbqs_pkg::div_req_t             div_req,
    input  tbqs_pkg::div_rsp_t             div_rsp,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           is_valid,
    output logic [2:0]                     warning_code,
    output logic [tbqs_pkg::Q_BITS-1:0]    quality_score,
    output logic [tbqs_pkg::Q_BITS-1:0]    readability,
    output logic [tbqs_pkg::Q_BITS-1:0]    word_quality,
    output logic                           has_artifacts,
    output logic                           length_overflow
);
    import tbqs_pkg::*;

    back_state_t              state_reg,   state_next;
    logic [LENGTH_BITS-1:0]   total_reg,   total_next;
    logic [LENGTH_BITS-1:0]   read_reg,    read_next;
    logic [CNT_BITS-1:0]      words_reg,   words_next;
    logic [CNT_BITS-1:0]      good_reg,    good_next;
    logic [WORD_LEN_BITS-1:0] wlen_reg,    wlen_next;
    logic [WORD_LEN_BITS-1:0] letters_reg, letters_next;
    logic [CNT_BITS-1:0]      srun_reg,    srun_next;
    logic                     sflag_reg,   sflag_next;
    logic [CNT_BITS-1:0]      ctrl_reg,    ctrl_next;
    logic [CNT_BITS-1:0]      lines_reg,   lines_next;
    logic [CNT_BITS-1:0]      single_reg,  single_next;
    logic [1:0]               llen_reg,    llen_next;

    logic [Q_BITS-1:0]        r_reg,       r_next;
    logic [Q_BITS-1:0]        w_reg,       w_next;
    logic                     art_reg,     art_next;
    logic                     empty_reg,   empty_next;
    logic [PROD_BITS-1:0]     prod_reg,    prod_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     is_valid_reg;
    warn_t                    code_reg;
    logic [Q_BITS-1:0]        score_out_reg;
    logic [Q_BITS-1:0]        r_out_reg;
    logic [Q_BITS-1:0]        w_out_reg;
    logic                     art_out_reg;
    logic                     ovf_out_reg;

    logic                     load_out;
    logic                     word_good;
    logic                     word_take;
    logic                     line_take;
    logic [CNT_BITS-1:0]      srun_inc;
    logic [2*CNT_BITS-1:0]    third_prod;
    logic [CNT_BITS-1:0]      lines_third;
    logic                     art_calc;
    logic [SUM_BITS-1:0]      score_sum;
    logic [Q_BITS-1:0]        score;

    assign word_good = ({letters_reg, 1'b0} >= {1'b0, wlen_reg})
                       || (wlen_reg <= WORD_LEN_BITS'(2));
    assign word_take = (wlen_reg != '0) && (words_reg < cfg.word_limit);
    assign line_take = (lines_reg < cfg.line_limit);
    assign srun_inc  = (srun_reg == CNT_MAX) ? srun_reg : srun_reg + 1'b1;

    assign third_prod  = (2*CNT_BITS)'(lines_reg) * (2*CNT_BITS)'(DIV3_MUL);
    assign lines_third = CNT_BITS'(third_prod >> DIV3_SHIFT);
    assign art_calc    = sflag_reg || (ctrl_reg > cfg.control_limit)
                         || ((lines_reg > cfg.min_lines) && (single_reg > lines_third));

    assign score_sum = SUM_BITS'({r_reg, 2'b00}) + SUM_BITS'(r_reg)
                     + SUM_BITS'({w_reg, 2'b00})
                     + (art_reg ? SUM_BITS'(0) : SUM_BITS'(Q_ONE));
    assign score     = prod_reg[DIV10_SHIFT +: Q_BITS];

    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        read_next    = read_reg;
        words_next   = words_reg;
        good_next    = good_reg;
        wlen_next    = wlen_reg;
        letters_next = letters_reg;
        srun_next    = srun_reg;
        sflag_next   = sflag_reg;
        ctrl_next    = ctrl_reg;
        lines_next   = lines_reg;
        single_next  = single_reg;
        llen_next    = llen_reg;
        r_next       = r_reg;
        w_next       = w_reg;
        art_next     = art_reg;
        empty_next   = empty_reg;
        prod_next    = prod_reg;
        q_pop        = 1'b0;
        div_req      = '0;
        load_out     = 1'b0;

        case (state_reg)
            ST_BYTE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_beat.present)
                    begin
                        if (total_reg != LEN_MAX)
                        begin
                            total_next = total_reg + 1'b1;
                            if (q_beat.readable)
                            begin
                                read_next = read_reg + 1'b1;
                            end
                        end

                        if (q_beat.separator)
                        begin
                            if (word_take)
                            begin
                                words_next = words_reg + 1'b1;
                                if (word_good)
                                begin
                                    good_next = good_reg + 1'b1;
                                end
                            end
                            wlen_next    = '0;
                            letters_next = '0;
                        end
                        else
                        begin
                            if (wlen_reg != WLEN_MAX)
                            begin
                                wlen_next = wlen_reg + 1'b1;
                            end
                            if (q_beat.letter && (letters_reg != WLEN_MAX))
                            begin
                                letters_next = letters_reg + 1'b1;
                            end
                        end

                        if (q_beat.space)
                        begin
                            srun_next = srun_inc;
                            if (srun_inc > cfg.space_run_limit)
                            begin
                                sflag_next = 1'b1;
                            end
                        end
                        else
                        begin
                            srun_next = '0;
                        end

                        if (q_beat.control && (ctrl_reg != CNT_MAX))
                        begin
                            ctrl_next = ctrl_reg + 1'b1;
                        end

                        if (q_beat.newline)
                        begin
                            if (line_take)
                            begin
                                lines_next = lines_reg + 1'b1;
                                if (llen_reg == 2'd1)
                                begin
                                    single_next = single_reg + 1'b1;
                                end
                            end
                            llen_next = '0;
                        end
                        else if (llen_reg != LINE_SAT)
                        begin
                            llen_next = llen_reg + 1'b1;
                        end
                    end
                    if (q_beat.last)
                    begin
                        state_next = ST_CLOSE;
                    end
                end
            end

            ST_CLOSE:
            begin
                // close the trailing word and a nonempty trailing line
                if (word_take)
                begin
                    words_next = words_reg + 1'b1;
                    if (word_good)
                    begin
                        good_next = good_reg + 1'b1;
                    end
                end
                wlen_next    = '0;
                letters_next = '0;
                if (llen_reg != '0)
                begin
                    if (line_take)
                    begin
                        lines_next = lines_reg + 1'b1;
                        if (llen_reg == 2'd1)
                        begin
                            single_next = single_reg + 1'b1;
                        end
                    end
                    llen_next = '0;
                end
                if (total_reg == '0)
                begin
                    empty_next = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    empty_next       = 1'b0;
                    div_req.start    = 1'b1;
                    div_req.dividend = read_reg;
                    div_req.divisor  = total_reg;
                    state_next       = ST_WAIT_R;
                end
            end

            ST_WAIT_R:
            begin
                art_next = art_calc;
                if (div_rsp.done)
                begin
                    r_next = div_rsp.quotient;
                    if (words_reg != '0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = LENGTH_BITS'(good_reg);
                        div_req.divisor  = LENGTH_BITS'(words_reg);
                        state_next       = ST_WAIT_W;
                    end
                    else
                    begin
                        w_next     = '0;
                        state_next = ST_SCORE;
                    end
                end
            end

            ST_WAIT_W:
            begin
                if (div_rsp.done)
                begin
                    w_next     = div_rsp.quotient;
                    state_next = ST_SCORE;
                end
            end

            ST_SCORE:
            begin
                prod_next  = score_sum * DIV10_MUL;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out     = 1'b1;
                    total_next   = '0;
                    read_next    = '0;
                    words_next   = '0;
                    good_next    = '0;
                    wlen_next    = '0;
                    letters_next = '0;
                    srun_next    = '0;
                    sflag_next   = 1'b0;
                    ctrl_next    = '0;
                    lines_next   = '0;
                    single_next  = '0;
                    llen_next    = '0;
                    state_next   = ST_BYTE;
                end
            end

            default:
            begin
                state_next = ST_BYTE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BYTE;
            total_reg     <= '0;
            read_reg      <= '0;
            words_reg     <= '0;
            good_reg      <= '0;
            wlen_reg      <= '0;
            letters_reg   <= '0;
            srun_reg      <= '0;
            sflag_reg     <= 1'b0;
            ctrl_reg      <= '0;
            lines_reg     <= '0;
            single_reg    <= '0;
            llen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            read_reg      <= read_next;
            words_reg     <= words_next;
            good_reg      <= good_next;
            wlen_reg      <= wlen_next;
            letters_reg   <= letters_next;
            srun_reg      <= srun_next;
            sflag_reg     <= sflag_next;
            ctrl_reg      <= ctrl_next;
            lines_reg     <= lines_next;
            single_reg    <= single_next;
            llen_reg      <= llen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        w_reg      <= w_next;
        art_reg    <= art_next;
        empty_reg  <= empty_next;
        prod_reg   <= prod_next;
        if (load_out)
        begin
            if (empty_reg)
            begin
                is_valid_reg  <= 1'b0;
                code_reg      <= WARN_EMPTY;
                score_out_reg <= '0;
                r_out_reg     <= '0;
                w_out_reg     <= '0;
                art_out_reg   <= 1'b0;
                ovf_out_reg   <= 1'b0;
            end
            else
            begin
                if (r_reg < cfg.min_readability)
                begin
                    is_valid_reg <= 1'b0;
                    code_reg     <= WARN_READABILITY;
                end
                else if (w_reg < cfg.min_word_quality)
                begin
                    is_valid_reg <= 1'b0;
                    code_reg     <= WARN_WORD_QUALITY;
                end
                else if (score < cfg.warning_threshold)
                begin
                    is_valid_reg <= 1'b1;
                    code_reg     <= WARN_SCORE;
                end
                else
                begin
                    is_valid_reg <= 1'b1;
                    code_reg     <= WARN_NONE;
                end
                score_out_reg <= score;
                r_out_reg     <= r_reg;
                w_out_reg     <= w_reg;
                art_out_reg   <= art_reg;
                ovf_out_reg   <= (total_reg == LEN_MAX);
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign is_valid        = is_valid_reg;
    assign warning_code    = code_reg;
    assign quality_score   = score_out_reg;
    assign readability     = r_out_reg;
    assign word_quality    = w_out_reg;
    assign has_artifacts   = art_out_reg;
    assign length_overflow = ovf_out_reg;

    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && load_out)
        |=> (total_reg == '0 && words_reg == '0 && lines_reg == '0 && !sflag_reg))
        else $error("counters not cleared after verdict");

    a_good_within_words: assert property (@(posedge clk) disable iff (!rst_n)
        good_reg <= words_reg)
        else $error("good word count exceeds sampled words");

    a_single_within_lines: assert property (@(posedge clk) disable iff (!rst_n)
        single_reg <= lines_reg)
        else $error("single-byte lines exceed sampled lines");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_no_pop_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT_R || state_reg == ST_WAIT_W) |-> !q_pop)
        else $error("beat taken during verdict");

endmodule

// ===== hw/rtl/text_byte_quality_scorer.sv =====
// Throughput: one text byte per cycle while a text is in progress and the queue is
//   not full. Verdict: the shared bit-serial divider works out readability, then
//   word quality; a text without words skips the second division, an empty text
//   skips both.
// Reset: rst_n clears all counters, the beat queue and the output valid flag and
//   loads the configuration registers with their defaults.
module text_byte_quality_scorer (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tbqs_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [tbqs_pkg::DATA_BITS-1:0]    pwdata,
    output logic [tbqs_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        text_byte,
    input  logic                              byte_present,
    input  logic                              last_byte,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              is_valid,
    output logic [2:0]                        warning_code,
    output logic [tbqs_pkg::Q_BITS-1:0]       quality_score,
    output logic [tbqs_pkg::Q_BITS-1:0]       readability,
    output logic [tbqs_pkg::Q_BITS-1:0]       word_quality,
    output logic                              has_artifacts,
    output logic                              length_overflow
);
    import tbqs_pkg::*;

    // Structure:
    //   front  - classify each incoming byte beat (readable, separator, letter,
    //            space, control, newline) and drop idle beats
    //   queue  - four-entry beat queue; the front keeps taking bytes while the
    //            back is busy working out a verdict
    //   back   - per-byte counters, then the end-of-text sequence: close the
    //            trailing word and line, up to two ratio divisions, the weighted score
    //            and the checks, into an output register
    //   div    - shared restoring divider, one quotient bit per cycle

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     cfg_write;

    beat_t    front_beat;
    beat_t    queue_beat;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Configuration registers: zero wait states, write on the access phase
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_MIN_READABILITY:   cfg_next.min_readability   = pwdata[Q_BITS-1:0];
                REG_MIN_WORD_QUALITY:  cfg_next.min_word_quality  = pwdata[Q_BITS-1:0];
                REG_WARNING_THRESHOLD: cfg_next.warning_threshold = pwdata[Q_BITS-1:0];
                REG_WORD_LIMIT:        cfg_next.word_limit        = pwdata[CNT_BITS-1:0];
                REG_LINE_LIMIT:        cfg_next.line_limit        = pwdata[CNT_BITS-1:0];
                REG_SPACE_RUN_LIMIT:   cfg_next.space_run_limit   = pwdata[CNT_BITS-1:0];
                REG_CONTROL_LIMIT:     cfg_next.control_limit     = pwdata[CNT_BITS-1:0];
                REG_MIN_LINES:         cfg_next.min_lines         = pwdata[CNT_BITS-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_READABILITY:   prdata = DATA_BITS'(cfg_reg.min_readability);
            REG_MIN_WORD_QUALITY:  prdata = DATA_BITS'(cfg_reg.min_word_quality);
            REG_WARNING_THRESHOLD: prdata = DATA_BITS'(cfg_reg.warning_threshold);
            REG_WORD_LIMIT:        prdata = DATA_BITS'(cfg_reg.word_limit);
            REG_LINE_LIMIT:        prdata = DATA_BITS'(cfg_reg.line_limit);
            REG_SPACE_RUN_LIMIT:   prdata = DATA_BITS'(cfg_reg.space_run_limit);
            REG_CONTROL_LIMIT:     prdata = DATA_BITS'(cfg_reg.control_limit);
            REG_MIN_LINES:         prdata = DATA_BITS'(cfg_reg.min_lines);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept and classify
    tbqs_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_beat       (front_beat)
    );

    // Decouple front from back
    tbqs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_beat (front_beat),
        .full      (q_full),
        .pop       (q_pop),
        .pop_beat  (queue_beat),
        .empty     (q_empty)
    );

    // Ratio divider, shared by readability and word quality
    tbqs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Count, close and score; hold the verdict beat until taken
    tbqs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_beat          (queue_beat),
        .q_pop           (q_pop),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .is_valid        (is_valid),
        .warning_code    (warning_code),
        .quality_score   (quality_score),
        .readability     (readability),
        .word_quality    (word_quality),
        .has_artifacts   (has_artifacts),
        .length_overflow (length_overflow)
    );

endmodule
